// ----- rtl/core/ffha_pkg.sv -----
`default_nettype none
package ffha_pkg;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_RD,
    ST_CHK,
    ST_SRD,
    ST_SCHK,
    ST_SPLIT,
    ST_DONE
  } state_e;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  localparam int unsigned REQ_W      = 20;
  localparam int unsigned ADDR_W     = 32;
  localparam int unsigned SPLIT_MIN  = 16;
  localparam int unsigned GRAIN_BITS = 3;

endpackage
`default_nettype wire

// ----- rtl/core/ffha_ram.sv -----
`default_nettype none
module ffha_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 32
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule
`default_nettype wire

// ----- rtl/core/first_fit_heap_allocator.sv -----
`default_nettype none
// channel  | signals                                         | dir
// ---------+-------------------------------------------------+-----
// request  | in_valid_i in_stall_o opcode_i request_bytes_i  | in
//          | release_address_i                               |
// result   | out_valid_o out_stall_i granted_address_o       | out
//          | success_o                                       |
// config   | cfg_we_i cfg_data_i (heap_base)                 | in
//
// Block headers live in one RAM indexed by block offset / 8 and are walked as a
// chain, one RAM read (RD, CHK) per block. An allocate takes the first free block
// that fits, splitting off a large enough rest in SPLIT; a free of block k also reads its
// successor (SRD, SCHK) to merge unless it is last. A zero, oversize or zero-address
// word goes straight to DONE. After reset INIT writes the arena-wide free block.
// A result waits in the output register under out_stall_i while the next word is taken.
module first_fit_heap_allocator #(
  parameter int unsigned ARENA_PAGES  = 128,
  parameter int unsigned PAGE_BYTES   = 4096,
  parameter int unsigned HEADER_BYTES = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [31:0] cfg_data_i,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic        opcode_i,
  input  wire logic [19:0] request_bytes_i,
  input  wire logic [31:0] release_address_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [31:0]      granted_address_o,
  output logic             success_o
);

  localparam int unsigned Arena = ARENA_PAGES * PAGE_BYTES;
  localparam int unsigned SzW   = $clog2(Arena + 1);
  localparam int unsigned Depth = Arena / 8;
  localparam int unsigned AW    = $clog2(Depth);
  localparam int unsigned EW    = SzW + 1;
  localparam int unsigned CW    = ((SzW > ffha_pkg::REQ_W) ? SzW : ffha_pkg::REQ_W) + 2;

  ffha_pkg::state_e state_q, state_d;

  logic [31:0]    base_q;
  logic           op_q, op_d;
  logic [SzW-1:0] need_q, need_d;
  logic [31:0]    off_q, off_d;
  logic [SzW-1:0] cur_q, cur_d;
  logic [SzW-1:0] csize_q, csize_d;
  logic [SzW-1:0] nxt_q, nxt_d;
  logic [SzW-1:0] prv_off_q, prv_off_d;
  logic [SzW-1:0] prv_size_q, prv_size_d;
  logic           prv_free_q, prv_free_d;
  logic [SzW-1:0] rem_q, rem_d;
  logic [31:0]    fin_addr_q, fin_addr_d;
  logic           fin_ok_q, fin_ok_d;
  logic           out_valid_q;
  logic [31:0]    out_addr_q;
  logic           out_ok_q;

  logic           ram_we;
  logic [AW-1:0]  ram_waddr, ram_raddr;
  logic [EW-1:0]  ram_wdata, ram_rdata;
  logic           r_free;
  logic [SzW-1:0] r_size;

  logic           in_acc, out_free;
  logic [CW-1:0]  req_ext, need_ext, size_ext;
  logic [SzW:0]   nxt_sum;
  logic           at_end, fit, split_ok, hit, req_bad;
  logic [SzW-1:0] merged, prv_merged;
  logic [31:0]    grant_addr;

  ffha_ram #(.Width(EW), .Depth(Depth)) u_hdr_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  assign r_free = ram_rdata[SzW];
  assign r_size = ram_rdata[SzW-1:0];

  assign in_stall_o = (state_q != ffha_pkg::ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  assign req_ext  = CW'(request_bytes_i);
  assign req_bad  = (request_bytes_i == '0) || (req_ext > CW'(Arena));
  assign need_ext = CW'(need_q);
  assign size_ext = CW'(r_size);

  assign nxt_sum  = (SzW+1)'(cur_q) + (SzW+1)'(HEADER_BYTES) + (SzW+1)'(r_size);
  assign at_end   = nxt_sum >= (SzW+1)'(Arena);
  assign fit      = r_free && (size_ext >= need_ext);
  assign split_ok = size_ext >= need_ext + CW'(HEADER_BYTES) + CW'(ffha_pkg::SPLIT_MIN);
  assign hit      = (32'(cur_q) == off_q);
  assign grant_addr = base_q + 32'(cur_q) + 32'(HEADER_BYTES);

  // freed block size after absorbing a free successor (successor data in SCHK)
  always_comb begin
    if (state_q == ffha_pkg::ST_SCHK) begin
      merged    = r_free ? SzW'(csize_q + SzW'(HEADER_BYTES) + r_size) : csize_q;
    end else begin
      merged    = r_size;
    end
  end
  assign prv_merged = SzW'(prv_size_q + SzW'(HEADER_BYTES) + merged);

  always_comb begin
    state_d = state_q;
    case (state_q)
      ffha_pkg::ST_INIT: state_d = ffha_pkg::ST_IDLE;
      ffha_pkg::ST_IDLE: begin
        if (in_acc) begin
          if (opcode_i == ffha_pkg::OP_ALLOC) begin
            state_d = req_bad ? ffha_pkg::ST_DONE : ffha_pkg::ST_RD;
          end else begin
            state_d = (release_address_i == '0) ? ffha_pkg::ST_DONE : ffha_pkg::ST_RD;
          end
        end
      end
      ffha_pkg::ST_RD:  state_d = ffha_pkg::ST_CHK;
      ffha_pkg::ST_CHK: begin
        if (op_q == ffha_pkg::OP_ALLOC) begin
          if (fit) begin
            state_d = split_ok ? ffha_pkg::ST_SPLIT : ffha_pkg::ST_DONE;
          end else begin
            state_d = at_end ? ffha_pkg::ST_DONE : ffha_pkg::ST_RD;
          end
        end else begin
          if (hit) begin
            state_d = at_end ? ffha_pkg::ST_DONE : ffha_pkg::ST_SRD;
          end else begin
            state_d = at_end ? ffha_pkg::ST_DONE : ffha_pkg::ST_RD;
          end
        end
      end
      ffha_pkg::ST_SRD:   state_d = ffha_pkg::ST_SCHK;
      ffha_pkg::ST_SCHK:  state_d = ffha_pkg::ST_DONE;
      ffha_pkg::ST_SPLIT: state_d = ffha_pkg::ST_DONE;
      ffha_pkg::ST_DONE:  state_d = out_free ? ffha_pkg::ST_IDLE : ffha_pkg::ST_DONE;
      default:            state_d = ffha_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    op_d       = op_q;
    need_d     = need_q;
    off_d      = off_q;
    cur_d      = cur_q;
    csize_d    = csize_q;
    nxt_d      = nxt_q;
    prv_off_d  = prv_off_q;
    prv_size_d = prv_size_q;
    prv_free_d = prv_free_q;
    rem_d      = rem_q;
    fin_addr_d = fin_addr_q;
    fin_ok_d   = fin_ok_q;
    ram_we     = 1'b0;
    ram_waddr  = cur_q[AW+ffha_pkg::GRAIN_BITS-1:ffha_pkg::GRAIN_BITS];
    ram_wdata  = '0;
    ram_raddr  = cur_q[AW+ffha_pkg::GRAIN_BITS-1:ffha_pkg::GRAIN_BITS];

    case (state_q)
      ffha_pkg::ST_INIT: begin
        ram_we    = 1'b1;
        ram_waddr = '0;
        ram_wdata = {1'b1, SzW'(Arena - HEADER_BYTES)};
      end
      ffha_pkg::ST_IDLE: begin
        if (in_acc) begin
          op_d       = opcode_i;
          need_d     = SzW'((req_ext + CW'(7)) & ~CW'(7));
          off_d      = release_address_i - base_q - 32'(HEADER_BYTES);
          cur_d      = '0;
          prv_free_d = 1'b0;
          fin_addr_d = '0;
          fin_ok_d   = (opcode_i == ffha_pkg::OP_FREE);
        end
      end
      ffha_pkg::ST_CHK: begin
        if (op_q == ffha_pkg::OP_ALLOC) begin
          if (fit) begin
            ram_we     = 1'b1;
            ram_wdata  = {1'b0, split_ok ? need_q : r_size};
            rem_d      = SzW'(r_size - need_q - SzW'(HEADER_BYTES));
            fin_addr_d = grant_addr;
            fin_ok_d   = 1'b1;
          end else begin
            cur_d = nxt_sum[SzW-1:0];
          end
        end else if (hit) begin
          csize_d = r_size;
          nxt_d   = nxt_sum[SzW-1:0];
          if (at_end) begin
            ram_we = 1'b1;
            if (prv_free_q) begin
              ram_waddr = prv_off_q[AW+ffha_pkg::GRAIN_BITS-1:ffha_pkg::GRAIN_BITS];
              ram_wdata = {1'b1, prv_merged};
            end else begin
              ram_wdata = {1'b1, merged};
            end
          end
        end else if (at_end) begin
          fin_ok_d = 1'b0;
        end else begin
          prv_off_d  = cur_q;
          prv_size_d = r_size;
          prv_free_d = r_free;
          cur_d      = nxt_sum[SzW-1:0];
        end
      end
      ffha_pkg::ST_SRD: begin
        ram_raddr = nxt_q[AW+ffha_pkg::GRAIN_BITS-1:ffha_pkg::GRAIN_BITS];
      end
      ffha_pkg::ST_SCHK: begin
        ram_we = 1'b1;
        if (prv_free_q) begin
          ram_waddr = prv_off_q[AW+ffha_pkg::GRAIN_BITS-1:ffha_pkg::GRAIN_BITS];
          ram_wdata = {1'b1, prv_merged};
        end else begin
          ram_wdata = {1'b1, merged};
        end
      end
      ffha_pkg::ST_SPLIT: begin
        ram_we    = 1'b1;
        nxt_d     = SzW'(cur_q + SzW'(HEADER_BYTES) + need_q);
        ram_waddr = nxt_d[AW+ffha_pkg::GRAIN_BITS-1:ffha_pkg::GRAIN_BITS];
        ram_wdata = {1'b1, rem_q};
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ffha_pkg::ST_INIT;
      base_q      <= '0;
      out_valid_q <= 1'b0;
      prv_free_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      prv_free_q <= prv_free_d;
      if (cfg_we_i) begin
        base_q <= cfg_data_i;
      end
      if (state_q == ffha_pkg::ST_DONE && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    op_q       <= op_d;
    need_q     <= need_d;
    off_q      <= off_d;
    cur_q      <= cur_d;
    csize_q    <= csize_d;
    nxt_q      <= nxt_d;
    prv_off_q  <= prv_off_d;
    prv_size_q <= prv_size_d;
    rem_q      <= rem_d;
    fin_addr_q <= fin_addr_d;
    fin_ok_q   <= fin_ok_d;
    if (state_q == ffha_pkg::ST_DONE && out_free) begin
      out_addr_q <= fin_addr_q;
      out_ok_q   <= fin_ok_q;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign granted_address_o = out_addr_q;
  assign success_o         = out_ok_q;

endmodule
`default_nettype wire

// ----- test/first_fit_heap_allocator_tb.sv -----
`default_nettype none
module first_fit_heap_allocator_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned ARENA_BYTES = 128 * 4096;
  localparam int unsigned HDR         = 16;
  localparam int unsigned MAX_BLK     = ARENA_BYTES / (HDR + 8) + 2;
  localparam int unsigned CYCLE_LIMIT = 1500000;
  localparam int unsigned N_RANDOM    = 400;

  typedef enum logic [1:0] {ADDR_LIT, ADDR_LAST, ADDR_ANY_LIVE, ADDR_STALE} addr_pick_e;

  typedef struct {
    logic        op;
    logic [19:0] req;
    logic [31:0] addr;
    addr_pick_e  pick;
  } request_t;

  typedef struct {
    bit [31:0] off;
    bit [31:0] size;
    bit        free;
  } block_t;

  typedef struct {
    logic [31:0] addr;
    logic        ok;
  } grant_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [31:0] cfg_data_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic        opcode_i = ffha_pkg::OP_ALLOC;
  logic [19:0] request_bytes_i = '0;
  logic [31:0] release_address_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [31:0] granted_address_o;
  logic        success_o;

  first_fit_heap_allocator DUT (.*);

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  request_t  pending_q[$];
  grant_t    grant_q[$];
  block_t    block_q[$];
  bit [31:0] live_q[$];
  bit [31:0] freed_q[$];
  bit [31:0] heap_base = '0;
  int        send_idle_pct = 0;
  int        recv_stall_pct = 0;
  int        n_errors = 0;
  int        n_cycles = 0;

  function automatic void heap_reset();
    block_t b;
    b.off  = 0;
    b.size = ARENA_BYTES - HDR;
    b.free = 1'b1;
    block_q = {b};
  endfunction

  function automatic grant_t heap_alloc(bit [31:0] req);
    grant_t    g;
    bit [31:0] need;
    block_t    rest;
    g.addr = '0;
    g.ok   = 1'b0;
    need = (req + 7) & ~32'd7;
    if (req == 0 || req > ARENA_BYTES) return g;
    foreach (block_q[i]) begin
      if (block_q[i].free && block_q[i].size >= need) begin
        if (block_q[i].size >= need + HDR + 16 && block_q.size() < MAX_BLK) begin
          rest.off  = block_q[i].off + HDR + need;
          rest.size = block_q[i].size - need - HDR;
          rest.free = 1'b1;
          block_q.insert(i + 1, rest);
          block_q[i].size = need;
        end
        block_q[i].free = 1'b0;
        live_q.push_back(block_q[i].off);
        g.addr = heap_base + block_q[i].off + HDR;
        g.ok   = 1'b1;
        return g;
      end
    end
    return g;
  endfunction

  function automatic grant_t heap_release(bit [31:0] addr);
    grant_t    g;
    bit [31:0] off;
    int        idx;
    g.addr = '0;
    g.ok   = 1'b1;
    if (addr == 0) return g;
    off = addr - heap_base - HDR;
    idx = -1;
    foreach (block_q[i]) if (idx < 0 && block_q[i].off == off) idx = i;
    if (idx < 0) begin
      g.ok = 1'b0;
      return g;
    end
    block_q[idx].free = 1'b1;
    foreach (live_q[i]) if (live_q[i] == off) begin
      live_q.delete(i);
      break;
    end
    freed_q.push_back(off);
    if (freed_q.size() > 8) void'(freed_q.pop_front());
    // coalesce with the following block, then the preceding one
    if (idx + 1 < block_q.size() && block_q[idx + 1].free) begin
      block_q[idx].size += HDR + block_q[idx + 1].size;
      block_q.delete(idx + 1);
    end
    if (idx > 0 && block_q[idx - 1].free) begin
      block_q[idx - 1].size += HDR + block_q[idx].size;
      block_q.delete(idx);
    end
    return g;
  endfunction

  function automatic logic [31:0] resolve_addr(request_t r);
    case (r.pick)
      ADDR_LAST:
        return live_q.size() ? heap_base + live_q[$] + HDR : 32'd0;
      ADDR_ANY_LIVE:
        return live_q.size() ?
          heap_base + live_q[$urandom_range(live_q.size() - 1)] + HDR : 32'd0;
      ADDR_STALE:
        return freed_q.size() ?
          heap_base + freed_q[$urandom_range(freed_q.size() - 1)] + HDR : heap_base + HDR;
      default: return r.addr;
    endcase
  endfunction

  // driver: predicts on acceptance, then loads the next word
  always @(posedge clk_i) begin
    request_t r;
    logic     nxt_valid;
    nxt_valid = in_valid_i;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        if (opcode_i == ffha_pkg::OP_ALLOC) begin
          grant_q.push_back(heap_alloc(32'(request_bytes_i)));
        end else begin
          grant_q.push_back(heap_release(release_address_i));
        end
        nxt_valid = 1'b0;
      end
      if (!nxt_valid && pending_q.size() && $urandom_range(99) >= send_idle_pct) begin
        r = pending_q.pop_front();
        opcode_i          <= r.op;
        request_bytes_i   <= (r.op == ffha_pkg::OP_ALLOC || $urandom_range(1)) ?
                             r.req : 20'($urandom);
        release_address_i <= r.op == ffha_pkg::OP_FREE ? resolve_addr(r) : $urandom;
        nxt_valid = 1'b1;
      end
    end
    in_valid_i <= nxt_valid;
  end

  always @(posedge clk_i) begin
    grant_t g;
    out_stall_i <= $urandom_range(99) < recv_stall_pct;
    n_cycles <= n_cycles + 1;
    if (n_cycles > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (grant_q.size() == 0) begin
        n_errors <= n_errors + 1;
        if (n_errors < 10) $display("unexpected word: addr %h ok %b",
                                    granted_address_o, success_o);
      end else begin
        g = grant_q.pop_front();
        if (g.addr !== granted_address_o || g.ok !== success_o) begin
          n_errors <= n_errors + 1;
          if (n_errors < 10) $display("mismatch: exp addr %h ok %b, got addr %h ok %b",
                                      g.addr, g.ok, granted_address_o, success_o);
        end
      end
    end
  end

  task automatic push_req(logic op, logic [19:0] req, addr_pick_e pick,
                          logic [31:0] addr = '0);
    request_t r;
    r.op = op;
    r.req = req;
    r.pick = pick;
    r.addr = addr;
    pending_q.push_back(r);
  endtask

  task automatic drain();
    wait (pending_q.size() == 0 && !in_valid_i && grant_q.size() == 0);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic write_base(logic [31:0] v);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_data_i <= v;
    heap_base  = v;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
  endtask

  function automatic logic [19:0] rand_size();
    int unsigned p;
    p = $urandom_range(99);
    if (p < 60) return 20'($urandom_range(1, 256));
    if (p < 85) return 20'($urandom_range(1, 4096));
    if (p < 93) return 20'($urandom_range(4097, 65536));
    if (p < 96) return 20'($urandom_range(65537, ARENA_BYTES));
    if (p < 98) return 20'($urandom_range(ARENA_BYTES + 1, 20'hFFFFF));
    return 20'd0;
  endfunction

  task automatic random_phase(int n);
    int unsigned p;
    repeat (n) begin
      p = $urandom_range(99);
      if (p < 48) push_req(ffha_pkg::OP_ALLOC, rand_size(), ADDR_LIT);
      else if (p < 70) push_req(ffha_pkg::OP_FREE, '0, ADDR_ANY_LIVE);
      else if (p < 90) push_req(ffha_pkg::OP_FREE, '0, ADDR_LAST);
      else if (p < 94) push_req(ffha_pkg::OP_FREE, '0, ADDR_STALE);
      else if (p < 97) push_req(ffha_pkg::OP_FREE, '0, ADDR_LIT, $urandom);
      else push_req(ffha_pkg::OP_FREE, '0, ADDR_LIT, '0);
    end
    drain();
  endtask

  initial begin
    heap_reset();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    write_base(32'h0000_0000);

    // whole arena, then zero, oversize and rounding cases
    push_req(ffha_pkg::OP_ALLOC, 20'(ARENA_BYTES - HDR), ADDR_LIT);
    push_req(ffha_pkg::OP_ALLOC, 20'd8, ADDR_LIT);
    push_req(ffha_pkg::OP_FREE, '0, ADDR_LAST);
    push_req(ffha_pkg::OP_FREE, '0, ADDR_STALE);
    push_req(ffha_pkg::OP_ALLOC, 20'd0, ADDR_LIT);
    push_req(ffha_pkg::OP_ALLOC, 20'(ARENA_BYTES), ADDR_LIT);
    push_req(ffha_pkg::OP_ALLOC, 20'(ARENA_BYTES + 1), ADDR_LIT);
    push_req(ffha_pkg::OP_ALLOC, 20'hFFFFF, ADDR_LIT);
    push_req(ffha_pkg::OP_ALLOC, 20'd1, ADDR_LIT);
    push_req(ffha_pkg::OP_ALLOC, 20'd40, ADDR_LIT);
    push_req(ffha_pkg::OP_ALLOC, 20'd9, ADDR_LIT);
    push_req(ffha_pkg::OP_ALLOC, 20'd40, ADDR_LIT);
    push_req(ffha_pkg::OP_FREE, '0, ADDR_LIT, 32'h0000_0000);
    push_req(ffha_pkg::OP_FREE, '0, ADDR_LIT, 32'hFFFF_FFFF);
    push_req(ffha_pkg::OP_FREE, '0, ADDR_LIT, 32'h0000_0014);
    // punch a hole, reuse it with a split, then merge on both sides
    push_req(ffha_pkg::OP_FREE, '0, ADDR_LIT, 32'h0000_0028);
    push_req(ffha_pkg::OP_ALLOC, 20'd8, ADDR_LIT);
    push_req(ffha_pkg::OP_FREE, '0, ADDR_LIT, 32'h0000_0010);
    push_req(ffha_pkg::OP_FREE, '0, ADDR_LIT, 32'h0000_0060);
    push_req(ffha_pkg::OP_FREE, '0, ADDR_LIT, 32'h0000_0028);
    push_req(ffha_pkg::OP_FREE, '0, ADDR_STALE);
    push_req(ffha_pkg::OP_FREE, '0, ADDR_ANY_LIVE);
    push_req(ffha_pkg::OP_ALLOC, 20'd24, ADDR_LIT);
    drain();

    write_base(32'hFFFF_FFF0);
    send_idle_pct = 25;
    recv_stall_pct = 81;
    random_phase(N_RANDOM);

    write_base({20'($urandom_range(32'hFFFFF)), 12'h000});
    send_idle_pct = 81;
    recv_stall_pct = 25;
    random_phase(N_RANDOM);

    write_base(32'hFFFF_FFFF);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    random_phase(N_RANDOM);

    repeat (100) @(posedge clk_i);
    if (n_errors == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule
`default_nettype wire
